### src/cacfar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CA-CFAR detector package
// Shared widths, register map, reset values and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cacfar_pkg;

    // configuration register widths
    localparam int HW_W    = 5;
    localparam int HG_W    = 4;
    localparam int SCALE_W = 16;

    // result and frame bookkeeping
    localparam int NOISE_W    = 36;
    localparam int FILL_W     = 6;
    localparam logic [FILL_W-1:0] FILL_LIMIT = 6'd63;

    // threshold arithmetic
    localparam int DIG_W   = 16;
    localparam int Q_SHIFT = 8;

    // APB register map
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_REACH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GUARD_REACH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE       = 2'd2;

    localparam logic [HW_W-1:0]    HW_RESET    = 5'd4;
    localparam logic [HG_W-1:0]    HG_RESET    = 4'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3537;

    typedef struct packed {
        logic [HW_W-1:0]    win_reach;
        logic [HG_W-1:0]    guard_reach;
        logic [SCALE_W-1:0] scale_factor_q8;
    } t_cfg;

    typedef struct packed {
        logic               detected;
        logic               tested;
        logic [NOISE_W-1:0] noise_sum;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic accept;
        logic scan_init;
        logic k_init;
        logic fill_clear;
        logic scan_step;
        logic mul_init;
        logic mul_step;
        logic acc_step;
        logic cmp;
        logic emit;
        logic emit_tested;
        logic k_dec;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic fill_gt_hw;
        logic test_ok;
        logic scan_last;
        logic pipe_busy;
        logic mul_last;
        logic k_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### src/cacfar_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CA-CFAR stream interfaces
// Valid/ready channels for the sample stream and the result stream.
// ----------------------------------------------------------------------------
interface cacfar_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface cacfar_result_if;
    logic                              valid;
    logic                              ready;
    logic                              detected;
    logic                              tested;
    logic [cacfar_pkg::NOISE_W-1:0]    noise_sum;
    logic                              last_result;

    modport source (output valid, output detected, output tested, output noise_sum,
                    output last_result, input ready);
    modport sink   (input valid, input detected, input tested, input noise_sum,
                    input last_result, output ready);
endinterface
`default_nettype wire

### src/cacfar_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cacfar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### src/cacfar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CA-CFAR controller
// Sequences one sample: decide; for a tested cell scan the window, form the
// threshold product and compare; then emit zero or more results.
// ----------------------------------------------------------------------------
module cacfar_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire cacfar_pkg::t_sts i_sts,
    output cacfar_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_DRAIN  = 4'd3;
    localparam logic [3:0] ST_SUB    = 4'd4;
    localparam logic [3:0] ST_MULT   = 4'd5;
    localparam logic [3:0] ST_MACC   = 4'd6;
    localparam logic [3:0] ST_CMP    = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_tst, n_tst;

    always_comb begin
        n_state = r_state;
        n_tst   = r_tst;
        o_cmd   = '0;
        o_in_ready = (r_state == ST_IDLE);
        o_cmd.accept      = i_in_valid && (r_state == ST_IDLE);
        o_cmd.emit_tested = r_tst;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.k_init     = 1'b1;
                o_cmd.fill_clear = i_sts.last;
                n_tst            = i_sts.test_ok;
                if (i_sts.last || i_sts.fill_gt_hw) begin
                    if (i_sts.test_ok) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the square/accumulate stages to empty
                if (!i_sts.pipe_busy) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                o_cmd.mul_init = 1'b1;
                n_state        = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mul_step = 1'b1;
                n_state        = ST_MACC;
            end
            ST_MACC: begin
                o_cmd.acc_step = 1'b1;
                n_state        = i_sts.mul_last ? ST_CMP : ST_MULT;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    // only the first cell of a burst can be a tested one
                    n_tst      = 1'b0;
                    if (!i_sts.last || i_sts.k_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.k_dec = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tst   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tst   <= n_tst;
        end
    end

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_DECIDE)
        else $error("accepted sample not followed by decide");

    a_sub_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SUB |-> !i_sts.pipe_busy)
        else $error("noise subtract started with scan pipeline busy");

endmodule
`default_nettype wire

### src/cacfar_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CA-CFAR datapath
// Sample ring in RAM, window scan with squaring and running sums,
// digit-serial threshold product, compare and output register.
// ----------------------------------------------------------------------------
module cacfar_dp #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int SAMPLE_BITS     = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cacfar_pkg::t_cfg       i_cfg,
    input  wire cacfar_pkg::t_cmd       i_cmd,
    output cacfar_pkg::t_sts            o_sts,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last_sample,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output cacfar_pkg::t_result         o_result
);

    localparam int HW_W    = cacfar_pkg::HW_W;
    localparam int FILL_W  = cacfar_pkg::FILL_W;
    localparam int DIG_W   = cacfar_pkg::DIG_W;
    localparam int SCALE_W = cacfar_pkg::SCALE_W;
    localparam int NOISE_W = cacfar_pkg::NOISE_W;

    localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + $clog2(DEPTH);
    localparam int CNT_W  = $clog2(2 * MAX_HALF_WINDOW + 1);
    localparam int NDIG   = (SUM_W + DIG_W - 1) / DIG_W;
    localparam int DIG_IW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int NPAD_W = NDIG * DIG_W;
    localparam int PP_W   = DIG_W + SCALE_W;
    localparam int PROD_W = NPAD_W + SCALE_W;
    localparam int LHS_W  = SQ_W + CNT_W;
    localparam int LSH_W  = LHS_W + cacfar_pkg::Q_SHIFT;
    localparam int CMP_W  = (LSH_W > PROD_W) ? LSH_W : PROD_W;

    // ring and frame state
    logic [ADDR_W-1:0] r_wp;
    logic [FILL_W-1:0] r_fill;
    logic              r_last;
    logic [HW_W-1:0]   r_k;

    // scan pipeline
    logic [ADDR_W-1:0]      r_rd_addr;
    logic [ADDR_W-1:0]      r_j;
    logic                   r_p1_vld, r_p2_vld;
    logic [ADDR_W-1:0]      r_p1_j, r_p2_j;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SQ_W-1:0]        r_sq, r_sq_c;
    logic [SUM_W-1:0]       r_wsum, r_gsum;

    // threshold arithmetic
    logic [NPAD_W-1:0] r_noise, r_nsh;
    logic [DIG_IW-1:0] r_dig;
    logic [PP_W-1:0]   r_pp;
    logic [PROD_W-1:0] r_prod;
    logic [LHS_W-1:0]  r_lhs;
    logic              r_det;

    logic                r_out_vld;
    cacfar_pkg::t_result r_out;

    // derived values
    logic [HW_W-1:0]        hw_eff;
    logic [HW_W-1:0]        hw_less_hg;
    logic [CNT_W-1:0]       ref_count;
    logic [ADDR_W-1:0]      hw_x, hg_x, hw2, guard_lo, guard_hi;
    logic [ADDR_W-1:0]      wp_next, rd_prev;
    logic [FILL_W-1:0]      fill_m1, hw_f;
    logic [HW_W-1:0]        k_start;
    logic [SAMPLE_BITS-1:0] mag;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic                   in_guard;
    logic [PROD_W-1:0]      pp_shifted;
    logic [CMP_W-1:0]       lhs_cmp, rhs_cmp;

    assign hw_eff = (i_cfg.win_reach > HW_W'(MAX_HALF_WINDOW)) ?
                    HW_W'(MAX_HALF_WINDOW) : i_cfg.win_reach;
    assign hw_less_hg = hw_eff - HW_W'(i_cfg.guard_reach);
    assign ref_count  = CNT_W'({hw_less_hg, 1'b0});

    assign hw_x     = ADDR_W'(hw_eff);
    assign hg_x     = ADDR_W'(i_cfg.guard_reach);
    assign hw2      = hw_x + hw_x;
    assign guard_lo = hw_x - hg_x;
    assign guard_hi = hw_x + hg_x;

    assign wp_next = (r_wp == ADDR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rd_prev = (r_rd_addr == '0) ? ADDR_W'(DEPTH - 1) : r_rd_addr - 1'b1;

    assign fill_m1 = r_fill - 1'b1;
    assign hw_f    = FILL_W'(hw_eff);
    assign k_start = r_last ? ((fill_m1 > hw_f) ? hw_eff : HW_W'(fill_m1)) : hw_eff;

    cacfar_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept),
        .i_wr_addr (wp_next),
        .i_wr_data (i_sample),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    assign mag     = rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data;
    assign sq_full = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
    assign in_guard = (r_p2_j >= guard_lo) && (r_p2_j <= guard_hi);

    assign pp_shifted = PROD_W'(r_pp) << (DIG_W * r_dig);
    assign lhs_cmp    = CMP_W'({r_lhs, {cacfar_pkg::Q_SHIFT{1'b0}}});
    assign rhs_cmp    = CMP_W'(r_prod);

    always_comb begin
        o_sts            = '0;
        o_sts.last       = r_last;
        o_sts.fill_gt_hw = r_fill > FILL_W'(hw_eff);
        o_sts.test_ok    = ((FILL_W+1)'(r_fill) > (FILL_W+1)'({hw_eff, 1'b0})) &&
                           (HW_W'(i_cfg.guard_reach) < hw_eff);
        o_sts.scan_last  = (r_j == hw2);
        o_sts.pipe_busy  = r_p1_vld || r_p2_vld;
        o_sts.mul_last   = (r_dig == DIG_IW'(NDIG - 1));
        o_sts.k_zero     = (r_k == '0);
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_fill    <= '0;
            r_last    <= 1'b0;
            r_k       <= '0;
            r_rd_addr <= '0;
            r_j       <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_dig     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_wp   <= wp_next;
                r_last <= i_last_sample;
                if (r_fill != cacfar_pkg::FILL_LIMIT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.fill_clear) begin
                r_fill <= '0;
            end

            if (i_cmd.k_init) begin
                r_k <= k_start;
            end else if (i_cmd.k_dec) begin
                r_k <= r_k - 1'b1;
            end

            // walk the ring from the newest sample backward
            if (i_cmd.scan_init) begin
                r_j       <= '0;
                r_rd_addr <= r_wp;
            end else if (i_cmd.scan_step) begin
                r_j       <= r_j + 1'b1;
                r_rd_addr <= rd_prev;
            end
            r_p1_vld <= i_cmd.scan_step;
            r_p2_vld <= r_p1_vld;

            if (i_cmd.mul_init) begin
                r_dig <= '0;
            end else if (i_cmd.acc_step) begin
                r_dig <= r_dig + 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_p1_j <= r_j;
        r_p2_j <= r_p1_j;
        r_sq   <= sq_full[SQ_W-1:0];

        if (i_cmd.scan_init) begin
            r_wsum <= '0;
            r_gsum <= '0;
        end else if (r_p2_vld) begin
            r_wsum <= r_wsum + SUM_W'(r_sq);
            if (in_guard) begin
                r_gsum <= r_gsum + SUM_W'(r_sq);
            end
            if (r_p2_j == hw_x) begin
                r_sq_c <= r_sq;
            end
        end

        if (i_cmd.mul_init) begin
            r_noise <= NPAD_W'(r_wsum - r_gsum);
            r_nsh   <= NPAD_W'(r_wsum - r_gsum);
            r_prod  <= '0;
            r_lhs   <= LHS_W'(r_sq_c) * LHS_W'(ref_count);
        end
        if (i_cmd.mul_step) begin
            r_pp <= PP_W'(r_nsh[DIG_W-1:0]) * PP_W'(i_cfg.scale_factor_q8);
        end
        if (i_cmd.acc_step) begin
            r_prod <= r_prod + pp_shifted;
            r_nsh  <= r_nsh >> DIG_W;
        end
        if (i_cmd.cmp) begin
            r_det <= lhs_cmp > rhs_cmp;
        end

        if (i_cmd.emit) begin
            r_out.detected    <= i_cmd.emit_tested && r_det;
            r_out.tested      <= i_cmd.emit_tested;
            r_out.noise_sum   <= i_cmd.emit_tested ? NOISE_W'(r_noise) : '0;
            r_out.last_result <= r_last && (r_k == '0);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    a_tested_is_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.emit_tested) |-> (r_k == hw_eff))
        else $error("tested result emitted for a cell other than the center");

    a_untested_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !i_cmd.emit_tested) |=> (!r_out.detected && r_out.noise_sum == '0))
        else $error("untested result carries detection or noise");

endmodule
`default_nettype wire

### src/cell_averaging_cfar_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell-averaging CFAR detector
// Takes one signed sample per transfer on i_in and gives one result per cell
// on o_out, one window reach of cells behind the input; the last sample of a
// frame flushes all held cells as a burst. A cell with a full window reach of
// neighbors on both sides is tested: square * count * 256 against
// noise_sum * scale.
// Registers (APB, byte address 4*i): window reach, guard reach, scale_factor_q8.
// Sequence: a sample that gives an untested result or none is decided and then
// emits its results one at a time. A tested cell adds the window scan through
// the sample RAM read port over 2*reach+1 cells, a drain of the scan pipeline,
// a subtract, a multiply and accumulate step per 16-bit digit of the noise sum
// (3 digits by default) and a compare.
// Reset clears the frame count, the sequencer and the output valid;
// registers return to 4, 1 and 3537. The sample RAM needs no clearing.
// A stalled receiver holds the result register; the block takes a new
// sample while a finished result still waits, and stalls only when a new
// result has nowhere to go.
// ----------------------------------------------------------------------------
module cell_averaging_cfar_detector_unit #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int SAMPLE_BITS     = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    cacfar_sample_if.sink                          i_in,
    cacfar_result_if.source                        o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cacfar_pkg::APB_AW-1:0]     paddr,
    input  wire logic [cacfar_pkg::APB_DW-1:0]     pwdata,
    output logic      [cacfar_pkg::APB_DW-1:0]     prdata,
    output logic                                   pready
);

    cacfar_pkg::t_cfg    r_cfg;
    cacfar_pkg::t_cmd    cmd;
    cacfar_pkg::t_sts    sts;
    cacfar_pkg::t_result result;
    logic                out_valid;
    logic                in_ready;
    logic                cfg_wr;
    logic [cacfar_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cacfar_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_reach       <= cacfar_pkg::HW_RESET;
            r_cfg.guard_reach     <= cacfar_pkg::HG_RESET;
            r_cfg.scale_factor_q8 <= cacfar_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            // unmapped addresses drop the transfer
            unique case (reg_idx)
                cacfar_pkg::REG_WIN_REACH:
                    r_cfg.win_reach <= pwdata[cacfar_pkg::HW_W-1:0];
                cacfar_pkg::REG_GUARD_REACH:
                    r_cfg.guard_reach <= pwdata[cacfar_pkg::HG_W-1:0];
                cacfar_pkg::REG_SCALE:
                    r_cfg.scale_factor_q8 <= pwdata[cacfar_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cacfar_pkg::REG_WIN_REACH:   prdata = cacfar_pkg::APB_DW'(r_cfg.win_reach);
            cacfar_pkg::REG_GUARD_REACH: prdata = cacfar_pkg::APB_DW'(r_cfg.guard_reach);
            cacfar_pkg::REG_SCALE:       prdata = cacfar_pkg::APB_DW'(r_cfg.scale_factor_q8);
            default:                     prdata = '0;
        endcase
    end

    cacfar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cacfar_dp #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (i_in.sample),
        .i_last_sample (i_in.last_sample),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_result      (result)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.detected    = result.detected;
    assign o_out.tested      = result.tested;
    assign o_out.noise_sum   = result.noise_sum;
    assign o_out.last_result = result.last_result;

endmodule
`default_nettype wire
